/* design/nbrtab_pkg.sv */
// ----------------------------------------------------------------------------
// nbrtab_pkg
// Shared types, constants and controller/datapath signal groups for the
// neighbour table.
// ----------------------------------------------------------------------------
`default_nettype none
package nbrtab_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int SLOT_W        = 6;
  localparam int ST_W          = 3;

  typedef logic [IDX_W-1:0] idx_t;

  localparam logic [ST_W-1:0] ST_INSERTED   = 3'd0;
  localparam logic [ST_W-1:0] ST_UPDATED    = 3'd1;
  localparam logic [ST_W-1:0] ST_EVICTED    = 3'd2;
  localparam logic [ST_W-1:0] ST_DROP_HINT  = 3'd3;
  localparam logic [ST_W-1:0] ST_DROP_YOUNG = 3'd4;
  localparam logic [ST_W-1:0] ST_HELLO      = 3'd5;
  localparam logic [ST_W-1:0] ST_NO_HELLO   = 3'd6;

  // where the result slot and hello payload come from
  localparam logic [1:0] RS_NONE = 2'd0;
  localparam logic [1:0] RS_IDX  = 2'd1;
  localparam logic [1:0] RS_OI   = 2'd2;
  localparam logic [1:0] RS_CAND = 2'd3;

  typedef struct packed {
    logic [31:0]        reuse_age_ms;
    logic signed [7:0]  immediate_threshold;
    logic signed [7:0]  recent_threshold;
    logic signed [7:0]  catchall_threshold;
    logic [31:0]        recency_ms;
    logic [31:0]        dry_spell_ms;
  } cfg_t;

  typedef struct packed {
    logic             capture;
    logic             rd_en;
    logic             rd_sel_cand;
    logic             wr_en;
    logic             wr_sel_oi;
    logic             set_valid;
    logic             clr_hello;
    logic             old_step;
    logic             hel_init;
    logic             hel_step;
    logic             set_hint;
    logic             hello_take;
    logic             res_load;
    logic [ST_W-1:0]  res_code;
    logic [1:0]       res_src;
    logic             out_load;
    idx_t             idx;
  } cmd_t;

  typedef struct packed {
    logic  mode;
    idx_t  start;
    logic  cur_valid;
    logic  addr_match;
    logic  hint_block;
    logic  young;
    logic  hello_ok;
  } sts_t;

endpackage
`default_nettype wire

/* design/nbrtab_dp.sv */
// ----------------------------------------------------------------------------
// nbrtab_dp
// Datapath: entry memory, valid/helloed bits, scan registers, hint and
// last-hello times, result and output registers.
// ----------------------------------------------------------------------------
`default_nettype none
module nbrtab_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire nbrtab_pkg::cmd_t            cmd,
  output nbrtab_pkg::sts_t                 sts,
  input  wire nbrtab_pkg::cfg_t            cfg,
  input  wire logic                        in_mode,
  input  wire logic [47:0]                 in_address,
  input  wire logic [5:0]                  in_adv_flags,
  input  wire logic signed [7:0]           in_rssi,
  input  wire logic [15:0]                 in_company_id,
  input  wire logic [31:0]                 in_now_ms,
  output logic [nbrtab_pkg::ST_W-1:0]      out_status,
  output logic [nbrtab_pkg::SLOT_W-1:0]    out_slot,
  output logic [15:0]                      out_hello_company,
  output logic signed [7:0]                out_hello_rssi
);
  import nbrtab_pkg::*;

  typedef struct packed {
    logic [47:0] addr;
    logic [7:0]  rssi;
    logic [31:0] heard;
    logic [5:0]  flags;
    logic [15:0] comp;
  } entry_t;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd_q_r;

  logic              mode_r;
  logic [47:0]       addr_r;
  logic [5:0]        flags_r;
  logic [7:0]        rssi_r;
  logic [15:0]       comp_r;
  logic [31:0]       now_r;

  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [TABLE_ENTRIES-1:0] helloed_r;

  logic [31:0]       oldest_r;
  idx_t              oi_r;
  logic signed [7:0] best_r;
  idx_t              cand_r;
  logic              have_r;
  logic [31:0]       next_exp_r;
  logic [31:0]       last_hello_r;

  logic [ST_W-1:0]   res_status_r;
  logic [SLOT_W-1:0] res_slot_r;
  logic [15:0]       res_comp_r;
  logic [7:0]        res_rssi_r;

  idx_t        rd_idx;
  idx_t        wr_idx;
  entry_t      wdata;
  logic [31:0] limit;
  logic [31:0] age_c;
  logic [31:0] since_hello;
  logic        ok_imm, ok_rec, ok_cat;

  assign rd_idx = cmd.rd_sel_cand ? cand_r : cmd.idx;
  assign wr_idx = cmd.wr_sel_oi ? oi_r : cmd.idx;
  assign wdata  = '{addr: addr_r, rssi: rssi_r, heard: now_r, flags: flags_r, comp: comp_r};

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[wr_idx] <= wdata;
    if (cmd.rd_en) rd_q_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      addr_r  <= in_address;
      flags_r <= in_adv_flags;
      rssi_r  <= in_rssi;
      comp_r  <= in_company_id;
      now_r   <= in_now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      helloed_r    <= '0;
      next_exp_r   <= '0;
      last_hello_r <= '0;
    end else begin
      if (cmd.set_valid) valid_r[wr_idx] <= 1'b1;
      if (cmd.clr_hello) helloed_r[wr_idx] <= 1'b0;
      if (cmd.hello_take) begin
        helloed_r[cand_r] <= 1'b1;
        last_hello_r      <= now_r;
      end
      if (cmd.set_hint) next_exp_r <= limit;
    end
  end

  // running minimum of heard time and maximum of rssi over the sweep
  always_ff @(posedge clk) begin
    if (cmd.old_step) begin
      if (cmd.idx == '0 || rd_q_r.heard < oldest_r) begin
        oldest_r <= rd_q_r.heard;
        oi_r     <= cmd.idx;
      end
    end
    if (cmd.hel_init) begin
      best_r <= -8'sd128;
      cand_r <= '0;
      have_r <= 1'b0;
    end else if (cmd.hel_step) begin
      if (valid_r[cmd.idx] && !helloed_r[cmd.idx] && $signed(rd_q_r.rssi) > best_r) begin
        best_r <= $signed(rd_q_r.rssi);
        cand_r <= cmd.idx;
        have_r <= 1'b1;
      end
    end
  end

  assign limit       = oldest_r + cfg.reuse_age_ms;
  assign age_c       = now_r - rd_q_r.heard;
  assign since_hello = now_r - last_hello_r;
  assign ok_imm      = best_r > cfg.immediate_threshold;
  assign ok_rec      = (best_r > cfg.recent_threshold) && (age_c < cfg.recency_ms);
  assign ok_cat      = (best_r > cfg.catchall_threshold) && (since_hello > cfg.dry_spell_ms);

  always_comb begin
    sts.mode       = mode_r;
    sts.start      = (addr_r[7:0] < 8'(TABLE_ENTRIES)) ? IDX_W'(addr_r[7:0]) : '0;
    sts.cur_valid  = valid_r[cmd.idx];
    sts.addr_match = rd_q_r.addr == addr_r;
    sts.hint_block = next_exp_r > now_r;
    sts.young      = limit > now_r;
    sts.hello_ok   = have_r && (ok_imm || ok_rec || ok_cat);
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status_r <= cmd.res_code;
      case (cmd.res_src)
        RS_IDX: begin
          res_slot_r <= SLOT_W'(cmd.idx);
          res_comp_r <= '0;
          res_rssi_r <= 8'h80;
        end
        RS_OI: begin
          res_slot_r <= SLOT_W'(oi_r);
          res_comp_r <= '0;
          res_rssi_r <= 8'h80;
        end
        RS_CAND: begin
          res_slot_r <= SLOT_W'(cand_r);
          res_comp_r <= rd_q_r.comp;
          res_rssi_r <= rd_q_r.rssi;
        end
        default: begin
          res_slot_r <= '0;
          res_comp_r <= '0;
          res_rssi_r <= 8'h80;
        end
      endcase
    end
    if (cmd.out_load) begin
      out_status        <= res_status_r;
      out_slot          <= res_slot_r;
      out_hello_company <= res_comp_r;
      out_hello_rssi    <= $signed(res_rssi_r);
    end
  end

endmodule
`default_nettype wire

/* design/nbrtab_ctrl.sv */
// ----------------------------------------------------------------------------
// nbrtab_ctrl
// Sequencer for probe walk, oldest-entry sweep and hello sweep; owns the
// handshakes.
// ----------------------------------------------------------------------------
`default_nettype none
module nbrtab_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output nbrtab_pkg::cmd_t        cmd,
  input  wire nbrtab_pkg::sts_t   sts
);
  import nbrtab_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SETUP = 4'd1;
  localparam logic [3:0] S_P_RD  = 4'd2;
  localparam logic [3:0] S_P_CK  = 4'd3;
  localparam logic [3:0] S_HINT  = 4'd4;
  localparam logic [3:0] S_O_RD  = 4'd5;
  localparam logic [3:0] S_O_CK  = 4'd6;
  localparam logic [3:0] S_O_END = 4'd7;
  localparam logic [3:0] S_H_RD  = 4'd8;
  localparam logic [3:0] S_H_CK  = 4'd9;
  localparam logic [3:0] S_H_FRD = 4'd10;
  localparam logic [3:0] S_H_END = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;

  localparam idx_t LAST = idx_t'(TABLE_ENTRIES - 1);

  logic [3:0] state_r, state_nxt;
  idx_t       idx_r, idx_nxt;
  idx_t       n_r, n_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    cmd.idx       = idx_r;
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SETUP;
        end
      end
      S_SETUP: begin
        n_nxt = '0;
        if (sts.mode) begin
          idx_nxt      = '0;
          cmd.hel_init = 1'b1;
          state_nxt    = S_H_RD;
        end else begin
          idx_nxt   = sts.start;
          state_nxt = S_P_RD;
        end
      end
      S_P_RD: begin
        if (!sts.cur_valid) begin
          cmd.wr_en     = 1'b1;
          cmd.set_valid = 1'b1;
          cmd.clr_hello = 1'b1;
          cmd.res_load  = 1'b1;
          cmd.res_code  = ST_INSERTED;
          cmd.res_src   = RS_IDX;
          state_nxt     = S_FIN;
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_P_CK;
        end
      end
      S_P_CK: begin
        if (sts.addr_match) begin
          cmd.wr_en    = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_code = ST_UPDATED;
          cmd.res_src  = RS_IDX;
          state_nxt    = S_FIN;
        end else if (n_r == LAST) begin
          state_nxt = S_HINT;
        end else begin
          idx_nxt   = (idx_r == LAST) ? '0 : idx_r + idx_t'(1);
          n_nxt     = n_r + idx_t'(1);
          state_nxt = S_P_RD;
        end
      end
      S_HINT: begin
        if (sts.hint_block) begin
          cmd.res_load = 1'b1;
          cmd.res_code = ST_DROP_HINT;
          cmd.res_src  = RS_NONE;
          state_nxt    = S_FIN;
        end else begin
          idx_nxt   = '0;
          state_nxt = S_O_RD;
        end
      end
      S_O_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_O_CK;
      end
      S_O_CK: begin
        cmd.old_step = 1'b1;
        if (idx_r == LAST) begin
          state_nxt = S_O_END;
        end else begin
          idx_nxt   = idx_r + idx_t'(1);
          state_nxt = S_O_RD;
        end
      end
      S_O_END: begin
        cmd.res_load = 1'b1;
        if (sts.young) begin
          cmd.set_hint = 1'b1;
          cmd.res_code = ST_DROP_YOUNG;
          cmd.res_src  = RS_NONE;
        end else begin
          cmd.wr_en     = 1'b1;
          cmd.wr_sel_oi = 1'b1;
          cmd.set_valid = 1'b1;
          cmd.clr_hello = 1'b1;
          cmd.res_code  = ST_EVICTED;
          cmd.res_src   = RS_OI;
        end
        state_nxt = S_FIN;
      end
      S_H_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_H_CK;
      end
      S_H_CK: begin
        cmd.hel_step = 1'b1;
        if (idx_r == LAST) begin
          state_nxt = S_H_FRD;
        end else begin
          idx_nxt   = idx_r + idx_t'(1);
          state_nxt = S_H_RD;
        end
      end
      S_H_FRD: begin
        cmd.rd_en       = 1'b1;
        cmd.rd_sel_cand = 1'b1;
        state_nxt       = S_H_END;
      end
      S_H_END: begin
        cmd.res_load = 1'b1;
        if (sts.hello_ok) begin
          cmd.hello_take = 1'b1;
          cmd.res_code   = ST_HELLO;
          cmd.res_src    = RS_CAND;
        end else begin
          cmd.res_code = ST_NO_HELLO;
          cmd.res_src  = RS_NONE;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hand over once the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_SETUP)
    else $error("accepted word did not start a sequence");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result loaded without valid");

  a_check_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_P_CK |-> $past(state_r) == S_P_RD)
    else $error("probe compare without prior read");

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_en |-> cmd.res_load)
    else $error("table write without result");

endmodule
`default_nettype wire

/* design/neighbor_table_with_age_eviction.sv */
// ----------------------------------------------------------------------------
// neighbor_table_with_age_eviction
// Neighbour table keyed by 48-bit address with oldest-entry eviction and
// hello-neighbour selection.
// ----------------------------------------------------------------------------
// One word in, one result word out. Words are handled one at a time by a
// sequencer that pairs each entry memory read with a check state. An
// advertisement probes up to N = TABLE_ENTRIES slots from its start slot;
// if none is free or matching and the hint does not block it, the whole
// table is swept for the oldest entry. A hello request sweeps the whole
// table. The next word is taken while the previous result waits in the
// output register. Configuration is at byte addresses 0x00..0x14, one
// 32-bit register each.
`default_nettype none
module neighbor_table_with_age_eviction (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_psel,
  input  wire logic                     cfg_penable,
  input  wire logic                     cfg_pwrite,
  input  wire logic [4:0]               cfg_paddr,
  input  wire logic [31:0]              cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_mode,
  input  wire logic [47:0]              in_address,
  input  wire logic [5:0]               in_adv_flags,
  input  wire logic signed [7:0]        in_rssi,
  input  wire logic [15:0]              in_company_id,
  input  wire logic [31:0]              in_now_ms,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [nbrtab_pkg::ST_W-1:0]   out_status,
  output logic [nbrtab_pkg::SLOT_W-1:0] out_slot,
  output logic [15:0]                   out_hello_company,
  output logic signed [7:0]             out_hello_rssi
);
  import nbrtab_pkg::*;

  localparam logic [2:0] REG_REUSE  = 3'd0;
  localparam logic [2:0] REG_IMM    = 3'd1;
  localparam logic [2:0] REG_REC    = 3'd2;
  localparam logic [2:0] REG_CATCH  = 3'd3;
  localparam logic [2:0] REG_RECENT = 3'd4;
  localparam logic [2:0] REG_DRY    = 3'd5;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;
  logic wr_c;

  assign cfg_pready = 1'b1;
  assign wr_c       = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reuse_age_ms        <= 32'd180000;
      cfg_r.immediate_threshold <= -8'sd50;
      cfg_r.recent_threshold    <= -8'sd80;
      cfg_r.catchall_threshold  <= -8'sd95;
      cfg_r.recency_ms          <= 32'd15000;
      cfg_r.dry_spell_ms        <= 32'd60000;
    end else if (wr_c) begin
      unique case (cfg_paddr[4:2])
        REG_REUSE:  cfg_r.reuse_age_ms        <= cfg_pwdata;
        REG_IMM:    cfg_r.immediate_threshold <= $signed(cfg_pwdata[7:0]);
        REG_REC:    cfg_r.recent_threshold    <= $signed(cfg_pwdata[7:0]);
        REG_CATCH:  cfg_r.catchall_threshold  <= $signed(cfg_pwdata[7:0]);
        REG_RECENT: cfg_r.recency_ms          <= cfg_pwdata;
        REG_DRY:    cfg_r.dry_spell_ms        <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      REG_REUSE:  cfg_prdata = cfg_r.reuse_age_ms;
      REG_IMM:    cfg_prdata = {24'd0, cfg_r.immediate_threshold};
      REG_REC:    cfg_prdata = {24'd0, cfg_r.recent_threshold};
      REG_CATCH:  cfg_prdata = {24'd0, cfg_r.catchall_threshold};
      REG_RECENT: cfg_prdata = cfg_r.recency_ms;
      REG_DRY:    cfg_prdata = cfg_r.dry_spell_ms;
      default:    cfg_prdata = '0;
    endcase
  end

  nbrtab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  nbrtab_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg               (cfg_r),
    .in_mode           (in_mode),
    .in_address        (in_address),
    .in_adv_flags      (in_adv_flags),
    .in_rssi           (in_rssi),
    .in_company_id     (in_company_id),
    .in_now_ms         (in_now_ms),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_hello_company (out_hello_company),
    .out_hello_rssi    (out_hello_rssi)
  );

endmodule
`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the neighbour table: directed table of words,
// then random advertisement/hello traffic checked against a local model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import nbrtab_pkg::*;

  localparam int N = TABLE_ENTRIES;
  localparam logic [4:0] A_REUSE = 5'h00, A_IMM = 5'h04, A_REC = 5'h08,
                         A_CATCH = 5'h0C, A_RECENCY = 5'h10, A_DRY = 5'h14;
  localparam logic MODE_ADV = 1'b0, MODE_HELLO = 1'b1;

  logic clk = 1'b0, rst_n = 1'b0;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [4:0] cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0, cfg_prdata;
  logic cfg_pready;
  logic in_valid = 0, in_ready, in_mode = 0;
  logic [47:0] in_address = 0;
  logic [5:0] in_adv_flags = 0;
  logic signed [7:0] in_rssi = 0;
  logic [15:0] in_company_id = 0;
  logic [31:0] in_now_ms = 0;
  logic out_valid, out_ready = 0;
  logic [ST_W-1:0] out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [15:0] out_hello_company;
  logic signed [7:0] out_hello_rssi;

  neighbor_table_with_age_eviction dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct {
    logic mode; logic [47:0] addr; logic [5:0] flags;
    logic signed [7:0] rssi; logic [15:0] comp; logic [31:0] now;
  } word_t;
  typedef struct {
    logic [ST_W-1:0] status; logic [SLOT_W-1:0] slot;
    logic [15:0] comp; logic signed [7:0] rssi;
  } res_t;

  // local copy of table state
  logic [31:0] reuse_age, recency, dry_spell;
  logic signed [7:0] thr_imm, thr_rec, thr_catch;
  logic t_valid[N], t_hello[N];
  logic [47:0] t_addr[N];
  logic signed [7:0] t_rssi[N];
  logic [31:0] t_heard[N];
  logic [15:0] t_comp[N];
  logic [31:0] hint_ms, last_hello;

  res_t expected_q[$];
  int errors = 0, n_words = 0, n_results = 0, n_hello = 0, n_evict = 0;

  function automatic res_t table_step(word_t w);
    res_t r;
    int idx, oi, best, cand;
    bit placed, have, ok;
    logic [31:0] oldest, lim;
    r = '{ST_NO_HELLO, 0, 0, -8'sd128};
    if (w.mode == MODE_ADV) begin
      idx = (w.addr[7:0] >= N) ? 0 : w.addr[7:0];
      placed = 0;
      for (int n = 0; n < N; n++) begin
        if (!t_valid[idx]) begin
          t_valid[idx] = 1; t_hello[idx] = 0; t_addr[idx] = w.addr;
          r.status = ST_INSERTED; placed = 1; break;
        end
        if (t_addr[idx] == w.addr) begin
          r.status = ST_UPDATED; placed = 1; break;
        end
        idx = (idx + 1 >= N) ? 0 : idx + 1;
      end
      if (!placed) begin
        if (hint_ms > w.now) begin
          r.status = ST_DROP_HINT; return r;
        end
        oi = 0; oldest = t_heard[0];
        for (int i = 1; i < N; i++)
          if (t_heard[i] < oldest) begin
            oldest = t_heard[i]; oi = i;
          end
        lim = oldest + reuse_age;
        if (lim > w.now) begin
          hint_ms = lim; r.status = ST_DROP_YOUNG; return r;
        end
        idx = oi; t_valid[idx] = 1; t_hello[idx] = 0; t_addr[idx] = w.addr;
        r.status = ST_EVICTED;
      end
      t_rssi[idx] = w.rssi; t_heard[idx] = w.now; t_comp[idx] = w.comp;
      r.slot = SLOT_W'(idx);
      return r;
    end
    best = -128; cand = 0; have = 0; ok = 0;
    for (int i = 0; i < N; i++)
      if (t_valid[i] && !t_hello[i] && int'(t_rssi[i]) > best) begin
        best = t_rssi[i]; cand = i; have = 1;
      end
    if (have) begin
      if (best > int'(thr_imm)) ok = 1;
      else if (best > int'(thr_rec) && (w.now - t_heard[cand]) < recency) ok = 1;
      else if (best > int'(thr_catch) && (w.now - last_hello) > dry_spell) ok = 1;
    end
    if (!ok) return r;
    last_hello = w.now; t_hello[cand] = 1;
    r = '{ST_HELLO, SLOT_W'(cand), t_comp[cand], t_rssi[cand]};
    return r;
  endfunction

  task automatic reg_write(logic [4:0] a, logic [31:0] d);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1; cfg_paddr <= a; cfg_pwdata <= d;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    case (a)
      A_REUSE:   reuse_age = d;
      A_IMM:     thr_imm = d[7:0];
      A_REC:     thr_rec = d[7:0];
      A_CATCH:   thr_catch = d[7:0];
      A_RECENCY: recency = d;
      default:   dry_spell = d;
    endcase
  endtask

  task automatic write_all(logic [31:0] ra, logic [7:0] im, logic [7:0] rc,
                           logic [7:0] ca, logic [31:0] rcy, logic [31:0] dry);
    reg_write(A_REUSE, ra); reg_write(A_IMM, {24'd0, im});
    reg_write(A_REC, {24'd0, rc}); reg_write(A_CATCH, {24'd0, ca});
    reg_write(A_RECENCY, rcy); reg_write(A_DRY, dry);
  endtask

  // bursty sender: expectation is queued at acceptance
  task automatic send_word(word_t w);
    in_valid <= 1; in_mode <= w.mode; in_address <= w.addr; in_adv_flags <= w.flags;
    in_rssi <= w.rssi; in_company_id <= w.comp; in_now_ms <= w.now;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(table_step(w));
    n_words++;
  endtask

  task automatic send_gap();
    int g;
    g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk); guard++;
    end
    repeat (300) @(posedge clk);
  endtask

  // receiver stalls on its own pattern
  logic [7:0] stall_lfsr = 8'h5A;
  always @(posedge clk) begin
    stall_lfsr <= {stall_lfsr[6:0], stall_lfsr[7] ^ stall_lfsr[5] ^ stall_lfsr[4] ^ stall_lfsr[3]};
    out_ready <= (stall_lfsr[2:0] != 3'b000) || stall_lfsr[7];
  end

  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word status=%0d slot=%0d", $time, out_status, out_slot);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (e.status == ST_HELLO) n_hello++;
        if (e.status == ST_EVICTED) n_evict++;
        if (out_status !== e.status || out_slot !== e.slot ||
            out_hello_company !== e.comp || out_hello_rssi !== e.rssi) begin
          $display("%0t: mismatch exp st=%0d slot=%0d comp=%h rssi=%0d act st=%0d slot=%0d comp=%h rssi=%0d",
                   $time, e.status, e.slot, e.comp, e.rssi,
                   out_status, out_slot, out_hello_company, out_hello_rssi);
          errors++;
        end
      end
    end
  end

  // directed rows; chk set where result is obvious
  typedef struct { word_t w; bit chk; res_t r; } row_t;
  row_t rows[$];

  function automatic word_t mk(logic m, logic [47:0] a, logic [5:0] f,
                               logic signed [7:0] rs, logic [15:0] c, logic [31:0] t);
    word_t w;
    w = '{m, a, f, rs, c, t};
    return w;
  endfunction

  task automatic run_random(int count, logic [47:0] pool_base, int pool);
    word_t w;
    logic [31:0] t;
    t = $urandom;
    for (int k = 0; k < count; k++) begin
      t += $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 30000);
      w.mode = ($urandom_range(0, 3) == 0);
      w.addr = ($urandom_range(0, 7) == 0) ? 48'({$urandom, $urandom}) :
               pool_base + 48'($urandom_range(0, pool - 1)) * 48'h1_0000_0001;
      w.flags = 6'($urandom); w.rssi = 8'($urandom); w.comp = 16'($urandom);
      w.now = ($urandom_range(0, 15) == 0) ? $urandom : t;
      send_word(w);
      send_gap();
    end
  endtask

  initial begin
    res_t r;
    for (int i = 0; i < N; i++) begin
      t_valid[i] = 0; t_hello[i] = 0; t_addr[i] = 0; t_rssi[i] = 0;
      t_heard[i] = 0; t_comp[i] = 0;
    end
    hint_ms = 0; last_hello = 0;
    reuse_age = 180000; thr_imm = -50; thr_rec = -80; thr_catch = -95;
    recency = 15000; dry_spell = 60000;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    rows.push_back('{mk(MODE_HELLO, 0, 0, 0, 0, 0), 1, '{ST_NO_HELLO, 0, 0, -8'sd128}});
    rows.push_back('{mk(MODE_ADV, 48'h0, 6'h3F, 127, 16'hFFFF, 0), 1,
                     '{ST_INSERTED, 0, 0, -8'sd128}});
    rows.push_back('{mk(MODE_ADV, 48'hFFFF_FFFF_FFFF, 0, -128, 0, 32'hFFFF_FFFF), 1,
                     '{ST_INSERTED, 1, 0, -8'sd128}});
    rows.push_back('{mk(MODE_ADV, 48'h3F, 6'h2A, -40, 16'h1234, 100), 1,
                     '{ST_INSERTED, 63, 0, -8'sd128}});
    rows.push_back('{mk(MODE_ADV, 48'h3F, 6'h15, -60, 16'h4321, 200), 1,
                     '{ST_UPDATED, 63, 0, -8'sd128}});
    rows.push_back('{mk(MODE_ADV, 48'h0000_0100_003F, 0, -90, 16'h0BAD, 300), 0, r});
    rows.push_back('{mk(MODE_HELLO, 48'hFFFF_FFFF_FFFF, 6'h3F, 127, 16'hFFFF, 1000),
                     1, '{ST_HELLO, 0, 16'hFFFF, 8'sd127}});
    rows.push_back('{mk(MODE_HELLO, 0, 0, 0, 0, 1100), 0, r});
    rows.push_back('{mk(MODE_HELLO, 0, 0, 0, 0, 100000), 0, r});
    rows.push_back('{mk(MODE_HELLO, 0, 0, 0, 0, 100001), 0, r});
    foreach (rows[i]) begin
      send_word(rows[i].w);
      if (rows[i].chk) expected_q[$] = rows[i].r;
    end
    drain();

    // fill the table to exercise hint, too-young and eviction paths
    write_all(32'd5000, 8'd127, 8'h80, 8'h80, 32'd0, 32'hFFFF_FFFF);
    for (int i = 0; i < N + 8; i++) begin
      send_word(mk(MODE_ADV, 48'hA000_0000_0000 + i, 6'($urandom), 8'($urandom),
                   16'($urandom), 32'd10 + i));
      send_gap();
    end
    send_word(mk(MODE_ADV, 48'hB000_0000_0001, 0, 0, 0, 32'd20));
    send_word(mk(MODE_ADV, 48'hB000_0000_0002, 0, 0, 0, 32'd6000));
    send_word(mk(MODE_HELLO, 0, 0, 0, 0, 32'd6000));
    drain();

    // thresholds -50, -80, -95
    write_all(32'hFFFF_FFFF, 8'hCE, 8'hB0, 8'hA1, 32'hFFFF_FFFF, 32'd0);
    run_random(300, 48'h0000_0000_0000, 90);
    drain();
    write_all(32'd0, 8'h80, 8'h80, 8'h80, 32'd15000, 32'd60000);
    run_random(350, 48'h1200_0000_0010, 120);
    drain();
    write_all(32'd40000, 8'h7F, 8'h7F, 8'h7F, 32'd0, 32'hFFFF_FFFF);
    run_random(200, 48'h0000_0000_0020, 70);
    drain();
    write_all(32'd180000, 8'hCE, 8'hB0, 8'hA1, 32'd15000, 32'd60000);
    run_random(415, 48'h0000_0000_0000, 100);
    drain();

    $display("Covered %0d input words, %0d results, %0d hellos, %0d evictions.",
             n_words, n_results, n_hello, n_evict);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("** neighbor_table_with_age_eviction: PASSED **");
    end else begin
      $display("** neighbor_table_with_age_eviction: FAILED **");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("** neighbor_table_with_age_eviction: FAILED **");
    $finish;
  end
endmodule
